/* src/window_watchdog_servicer_macros.svh */
// ----------------------------------------------------------------------------
// Window watchdog servicer assertion macros
// Shared concurrent assertion forms, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WINDOW_WATCHDOG_SERVICER_MACROS_SVH
`define WINDOW_WATCHDOG_SERVICER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clock, off during reset
`define WWS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication, sampled on clock, off during reset
`define WWS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define WWS_ASSERT_IMP(label, ante, cons, msg)
`define WWS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* src/wws_pkg.sv */
// ----------------------------------------------------------------------------
// Window watchdog servicer package
// Command and action codes, register indexes, shared structs, frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package wws_pkg;

   localparam int ADDR_W     = 6;
   localparam int DATA_W     = 16;
   localparam int WIN_W      = 16;
   localparam int TIME_W     = 32;
   localparam int FRAME_W    = 32;
   localparam int CNT_W      = 32;
   localparam int PARITY_BIT = 24;

   localparam logic [WIN_W-1:0]  CLOSED_RESET = 16'd5;
   localparam logic [WIN_W-1:0]  OPEN_RESET   = 16'd10;
   localparam logic [ADDR_W-1:0] ADDR_RESET   = 6'd0;
   localparam logic [DATA_W-1:0] TOGGLE_MASK  = 16'h0001;

   typedef enum logic [1:0] {
      CMD_TICK     = 2'd0,
      CMD_START    = 2'd1,
      CMD_RESPONSE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ACT_SERVICE = 2'd0,
      ACT_MISS    = 2'd1,
      ACT_WRITE   = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      CSR_CLOSED = 2'd0,
      CSR_OPEN   = 2'd1,
      CSR_ADDR   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [WIN_W-1:0]  closed_window_ms;
      logic [WIN_W-1:0]  open_window_ms;
      logic [ADDR_W-1:0] service_reg_addr;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic [FRAME_W-1:0] tx_frame;
      action_type         action;
      logic               wdi_level;
      logic [CNT_W-1:0]   service_total;
      logic [CNT_W-1:0]   miss_total;
   } result_type;

   function automatic logic [FRAME_W-1:0] make_frame(
      input logic              wr,
      input logic [ADDR_W-1:0] addr,
      input logic [DATA_W-1:0] data
   );
      logic [FRAME_W-1:0] f;
      f = {wr, addr, 1'b0, data, 8'h00};
      f[PARITY_BIT] = ^f[FRAME_W-1:8];
      return f;
   endfunction

endpackage

`default_nettype wire

/* src/wws_core.sv */
// ----------------------------------------------------------------------------
// Window watchdog servicer core
// Servicing state, window compare and frame build for one beat per cycle, advancing only on fire.
// ----------------------------------------------------------------------------
`default_nettype none
`include "window_watchdog_servicer_macros.svh"

module wws_core
   import wws_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fire,
   input  wire logic [1:0]         command,
   input  wire logic [TIME_W-1:0]  now_ms,
   input  wire logic [FRAME_W-1:0] rx_frame,
   input  wire cfg_type            cfg,
   output result_type              res
);

   logic              active_ff, active_in;
   logic [TIME_W-1:0] last_ff, last_in;
   logic              wdi_ff, wdi_in;
   logic              pend_ff, pend_in;
   logic [CNT_W-1:0]  svc_ff, svc_in;
   logic [CNT_W-1:0]  miss_ff, miss_in;

   logic [TIME_W-1:0] elapsed;
   logic [WIN_W:0]    wend;
   logic              in_window;
   logic              past_end;

   assign elapsed   = now_ms - last_ff;
   assign wend      = {1'b0, cfg.closed_window_ms} + {1'b0, cfg.open_window_ms};
   assign in_window = (elapsed >= {{(TIME_W-WIN_W){1'b0}}, cfg.closed_window_ms})
                   && (elapsed < {{(TIME_W-WIN_W-1){1'b0}}, wend});
   assign past_end  = elapsed >= {{(TIME_W-WIN_W-1){1'b0}}, wend};

   always_comb begin
      active_in    = active_ff;
      last_in      = last_ff;
      wdi_in       = wdi_ff;
      pend_in      = pend_ff;
      svc_in       = svc_ff;
      miss_in      = miss_ff;
      res.valid    = 1'b0;
      res.action   = ACT_SERVICE;
      res.tx_frame = make_frame(1'b0, cfg.service_reg_addr, '0);
      case (cmd_type'(command))
         CMD_START: begin
            active_in = 1'b1;
            last_in   = now_ms;
            wdi_in    = ~wdi_ff;
            pend_in   = 1'b1;
            res.valid = 1'b1;
         end
         CMD_TICK: begin
            if (active_ff && (in_window || past_end)) begin
               last_in   = now_ms;
               wdi_in    = ~wdi_ff;
               pend_in   = 1'b1;
               res.valid = 1'b1;
               if (in_window) begin
                  svc_in = svc_ff + CNT_W'(1);
               end else begin
                  miss_in    = miss_ff + CNT_W'(1);
                  res.action = ACT_MISS;
               end
            end
         end
         CMD_RESPONSE: begin
            if (pend_ff) begin
               pend_in      = 1'b0;
               res.valid    = 1'b1;
               res.action   = ACT_WRITE;
               res.tx_frame = make_frame(1'b1, cfg.service_reg_addr,
                                         rx_frame[8 +: DATA_W] ^ TOGGLE_MASK);
            end
         end
         default: begin
         end
      endcase
      res.wdi_level     = wdi_in;
      res.service_total = svc_in;
      res.miss_total    = miss_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         last_ff   <= '0;
         wdi_ff    <= 1'b0;
         pend_ff   <= 1'b0;
         svc_ff    <= '0;
         miss_ff   <= '0;
      end else if (fire) begin
         active_ff <= active_in;
         last_ff   <= last_in;
         wdi_ff    <= wdi_in;
         pend_ff   <= pend_in;
         svc_ff    <= svc_in;
         miss_ff   <= miss_in;
      end
   end

   `WWS_ASSERT_NEXT(a_miss_step, fire && res.valid && res.action == ACT_MISS, miss_ff == $past(miss_ff) + CNT_W'(1), "miss counter did not advance by one")
   `WWS_ASSERT_NEXT(a_wdi_toggle, fire && res.valid && res.action != ACT_WRITE, wdi_ff != $past(wdi_ff), "WDI level did not toggle on a read")
   `WWS_ASSERT_NEXT(a_write_clears, fire && res.valid && res.action == ACT_WRITE, !pend_ff && $past(pend_ff), "write issued without a pending read")

endmodule

`default_nettype wire

/* src/window_watchdog_servicer.sv */
// ----------------------------------------------------------------------------
// Window watchdog servicer
// Services an external window watchdog over 32-bit SPI frames.
// ----------------------------------------------------------------------------
// A request beat is taken into the input register, and its result is then registered in the result register.
// Throughput: one request beat per cycle while the result is not stalled, set by the input and result registers.
// A stalled result holds the core; one further request beat waits in the input register.
// Reset: synchronous; clears servicing state, counters and valids,
// and sets the window registers to 5 ms closed, 10 ms open, address 0.
`default_nettype none
`include "window_watchdog_servicer_macros.svh"

module window_watchdog_servicer
   import wws_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [WIN_W-1:0]   csr_wdata,

   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_command,
   input  wire logic [TIME_W-1:0]  req_now_ms,
   input  wire logic [FRAME_W-1:0] req_rx_frame,

   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [FRAME_W-1:0]      rsp_tx_frame,
   output logic [1:0]              rsp_action,
   output logic                    rsp_wdi_level,
   output logic [CNT_W-1:0]        rsp_service_total,
   output logic [CNT_W-1:0]        rsp_miss_total
);

   cfg_type            cfg_ff;

   logic               s1_valid_ff;
   logic [1:0]         s1_command_ff;
   logic [TIME_W-1:0]  s1_now_ff;
   logic [FRAME_W-1:0] s1_rx_ff;

   logic               out_valid_ff;
   result_type         out_ff;

   logic               advance;
   logic               fire;
   result_type         core_res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.closed_window_ms <= CLOSED_RESET;
         cfg_ff.open_window_ms   <= OPEN_RESET;
         cfg_ff.service_reg_addr <= ADDR_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_CLOSED: cfg_ff.closed_window_ms <= csr_wdata;
            CSR_OPEN:   cfg_ff.open_window_ms   <= csr_wdata;
            CSR_ADDR:   cfg_ff.service_reg_addr <= csr_wdata[ADDR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_command_ff <= req_command;
         s1_now_ff     <= req_now_ms;
         s1_rx_ff      <= req_rx_frame;
      end
   end

   wws_core u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .command  (s1_command_ff),
      .now_ms   (s1_now_ff),
      .rx_frame (s1_rx_ff),
      .cfg      (cfg_ff),
      .res      (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff && core_res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= core_res;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_tx_frame      = out_ff.tx_frame;
   assign rsp_action        = out_ff.action;
   assign rsp_wdi_level     = out_ff.wdi_level;
   assign rsp_service_total = out_ff.service_total;
   assign rsp_miss_total    = out_ff.miss_total;

   `WWS_ASSERT_IMP(a_frame_parity, rsp_valid, ^rsp_tx_frame[FRAME_W-1:8] == 1'b0, "frame parity is odd")
   `WWS_ASSERT_IMP(a_write_flag, rsp_valid, rsp_tx_frame[FRAME_W-1] == (rsp_action == ACT_WRITE), "write flag does not match action")
   `WWS_ASSERT_IMP(a_read_data, rsp_valid && rsp_action != ACT_WRITE, rsp_tx_frame[8 +: DATA_W] == '0, "read frame carries data")

endmodule

`default_nettype wire
